[sv/planar_odometry_integrator_macros.svh]
// Assertion macros shared by the odometry integrator modules.
// No dependencies; each module that asserts includes this header.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_MACROS_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define PO_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PO_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PO_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PO_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[sv/po_int_pkg.sv]
// Shared types, constants and the arctangent table of the odometry integrator.
// No dependencies.
package po_int_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
  localparam int STEP_W       = 5;

  localparam int RATE_W  = 16;
  localparam int SPEED_W = 16;
  localparam int DT_W    = 17;
  localparam int POS_W   = 32;
  localparam int HEAD_W  = 32;

  localparam int PROD_W  = 34;
  localparam int MA_W    = 18;
  localparam int MB_W    = 31;
  localparam int MP_W    = MA_W + MB_W;
  localparam int ACC_W   = 64;
  localparam int TURN_W  = 36;
  localparam int DIST_W  = 34;
  localparam int CV_W    = 36;
  localparam int Z_W     = 34;
  localparam int DPOS_W  = CV_W - 8;
  localparam int SUM_W   = 34;

  localparam logic signed [MB_W-1:0] RAD_TO_BAM   = 31'sd683565276;
  localparam logic signed [MB_W-1:0] GAIN_INV_Q30 = 31'sd652032874;

  localparam logic [1:0] MOP_TLO = 2'd0;
  localparam logic [1:0] MOP_THI = 2'd1;
  localparam logic [1:0] MOP_DLO = 2'd2;
  localparam logic [1:0] MOP_DHI = 2'd3;

  typedef struct packed {
    logic              load;
    logic              prod;
    logic              mul_en;
    logic [1:0]        mul_op;
    logic              rnd;
    logic              init;
    logic              rot;
    logic [STEP_W-1:0] step;
    logic              commit;
  } po_cmd_t;

  function automatic logic [29:0] atan_bam(input logic [STEP_W-1:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

[sv/po_int_ctrl.sv]
// Sequencer of the odometry integrator: steps the datapath through one request.
// Depends on po_int_pkg and the assertion macro header.
`include "planar_odometry_integrator_macros.svh"
module po_int_ctrl
  import po_int_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output po_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PROD = 4'd1;
  localparam logic [3:0] ST_TLO  = 4'd2;
  localparam logic [3:0] ST_THI  = 4'd3;
  localparam logic [3:0] ST_DLO  = 4'd4;
  localparam logic [3:0] ST_DHI  = 4'd5;
  localparam logic [3:0] ST_RND  = 4'd6;
  localparam logic [3:0] ST_INIT = 4'd7;
  localparam logic [3:0] ST_ROT  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_ITERS - 1);

  logic [3:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;
  logic              out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    cmd            = '0;
    cmd.step       = step_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = accept;
        if (accept) state_nxt = ST_PROD;
      end
      ST_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = ST_TLO;
      end
      ST_TLO: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MOP_TLO;
        state_nxt  = ST_THI;
      end
      ST_THI: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MOP_THI;
        state_nxt  = ST_DLO;
      end
      ST_DLO: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MOP_DLO;
        state_nxt  = ST_DHI;
      end
      ST_DHI: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MOP_DHI;
        state_nxt  = ST_RND;
      end
      ST_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_ROT;
      end
      ST_ROT: begin
        cmd.rot  = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.commit = out_free;
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PO_ASSERT_NXT(a_accept_starts, clk, rst_n, accept, state_r == ST_PROD)
  `PO_ASSERT_NXT(a_init_clears_step, clk, rst_n, state_r == ST_INIT, step_r == '0)
  `PO_ASSERT_NXT(a_rot_ends, clk, rst_n, (state_r == ST_ROT) && (step_r == LAST_STEP),
                 state_r == ST_DONE)
  `PO_ASSERT_NXT(a_commit_shows, clk, rst_n, cmd.commit, out_valid_r)

endmodule

[sv/po_int_dp.sv]
// Datapath of the odometry integrator: shared scaling multiplier, CORDIC rotator
// and pose accumulators. Depends on po_int_pkg and the assertion macro header.
`include "planar_odometry_integrator_macros.svh"
module po_int_dp
  import po_int_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  po_cmd_t                   cmd,
  input  logic signed [RATE_W-1:0]  yaw_rate,
  input  logic signed [SPEED_W-1:0] speed,
  input  logic        [DT_W-1:0]    time_step,
  output logic signed [POS_W-1:0]   pos_x,
  output logic signed [POS_W-1:0]   pos_y,
  output logic        [HEAD_W-1:0]  heading
);

  logic signed [RATE_W-1:0]  rate_r;
  logic signed [SPEED_W-1:0] speed_r;
  logic        [DT_W-1:0]    dt_r;
  logic signed [PROD_W-1:0]  prod_turn_r, prod_dist_r;
  logic signed [ACC_W-1:0]   acc_turn_r, acc_dist_r;
  logic signed [TURN_W-1:0]  turn_r;
  logic signed [DIST_W-1:0]  dist_r;
  logic signed [CV_W-1:0]    cx_r, cy_r;
  logic signed [Z_W-1:0]     z_r;
  logic signed [POS_W-1:0]   x_accum_r, y_accum_r;
  logic        [HEAD_W-1:0]  heading_r;

  // shared multiplier
  logic signed [PROD_W-1:0] mul_src;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [MP_W-1:0]   mul_p;
  logic signed [ACC_W-1:0]  mul_ext;
  logic signed [ACC_W-1:0]  acc_cur;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic                     mul_hi;

  always_comb begin
    mul_hi  = (cmd.mul_op == MOP_THI) || (cmd.mul_op == MOP_DHI);
    mul_src = mul_hi ? ((cmd.mul_op == MOP_THI) ? prod_turn_r : prod_dist_r)
                     : ((cmd.mul_op == MOP_TLO) ? prod_turn_r : prod_dist_r);
    mul_b   = ((cmd.mul_op == MOP_TLO) || (cmd.mul_op == MOP_THI)) ? RAD_TO_BAM
                                                                  : GAIN_INV_Q30;
    acc_cur = ((cmd.mul_op == MOP_TLO) || (cmd.mul_op == MOP_THI)) ? acc_turn_r
                                                                  : acc_dist_r;
    if (mul_hi) begin
      mul_a = MA_W'(mul_src >>> 17);
    end else begin
      mul_a = $signed({1'b0, mul_src[16:0]});
    end
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_ext = ACC_W'(mul_p);
  assign acc_nxt = mul_hi ? (acc_cur + (mul_ext <<< 17)) : mul_ext;

  // rounding of the scaled products
  logic signed [ACC_W-1:0] turn_rnd, dist_rnd;
  assign turn_rnd = (acc_turn_r + (ACC_W'(1) <<< 27)) >>> 28;
  assign dist_rnd = (acc_dist_r + (ACC_W'(1) <<< 29)) >>> 30;

  // midpoint angle and quadrant fold
  logic [HEAD_W-1:0]      mid;
  logic                   flip;
  logic signed [CV_W-1:0] dist_ext;
  assign mid      = heading_r + turn_r[HEAD_W:1];
  assign flip     = mid[31] ^ mid[30];
  assign dist_ext = CV_W'(dist_r);

  // one rotation
  logic signed [CV_W-1:0] xs, ys, cx_nxt, cy_nxt;
  logic signed [Z_W-1:0]  atan_v, z_nxt;
  assign xs     = cx_r >>> cmd.step;
  assign ys     = cy_r >>> cmd.step;
  assign atan_v = Z_W'(atan_bam(cmd.step));

  always_comb begin
    if (!z_r[Z_W-1]) begin
      cx_nxt = cx_r - ys;
      cy_nxt = cy_r + xs;
      z_nxt  = z_r - atan_v;
    end else begin
      cx_nxt = cx_r + ys;
      cy_nxt = cy_r - xs;
      z_nxt  = z_r + atan_v;
    end
  end

  // position update with saturation
  logic signed [CV_W-1:0]  cx_rnd, cy_rnd;
  logic signed [SUM_W-1:0] x_sum, y_sum;
  logic signed [POS_W-1:0] x_nxt, y_nxt;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v[SUM_W-1:POS_W-1] == '0 || v[SUM_W-1:POS_W-1] == '1) begin
      r = v[POS_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end
    return r;
  endfunction

  assign cx_rnd = (cx_r + CV_W'(128)) >>> 8;
  assign cy_rnd = (cy_r + CV_W'(128)) >>> 8;
  assign x_sum  = SUM_W'(x_accum_r) + SUM_W'($signed(cx_rnd[DPOS_W-1:0]));
  assign y_sum  = SUM_W'(y_accum_r) + SUM_W'($signed(cy_rnd[DPOS_W-1:0]));
  assign x_nxt  = sat_pos(x_sum);
  assign y_nxt  = sat_pos(y_sum);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rate_r  <= yaw_rate;
      speed_r <= speed;
      dt_r    <= time_step;
    end
    if (cmd.prod) begin
      prod_turn_r <= rate_r * $signed({1'b0, dt_r});
      prod_dist_r <= speed_r * $signed({1'b0, dt_r});
    end
    if (cmd.mul_en) begin
      if ((cmd.mul_op == MOP_TLO) || (cmd.mul_op == MOP_THI)) begin
        acc_turn_r <= acc_nxt;
      end else begin
        acc_dist_r <= acc_nxt;
      end
    end
    if (cmd.rnd) begin
      turn_r <= turn_rnd[TURN_W-1:0];
      dist_r <= dist_rnd[DIST_W-1:0];
    end
    if (cmd.init) begin
      cx_r <= flip ? -dist_ext : dist_ext;
      cy_r <= '0;
      z_r  <= Z_W'($signed({mid[31] ^ flip, mid[30:0]}));
    end else if (cmd.rot) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      z_r  <= z_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_accum_r <= '0;
      y_accum_r <= '0;
      heading_r <= '0;
    end else if (cmd.commit) begin
      x_accum_r <= x_nxt;
      y_accum_r <= y_nxt;
      heading_r <= heading_r + turn_r[HEAD_W-1:0];
    end
  end

  assign pos_x   = x_accum_r;
  assign pos_y   = y_accum_r;
  assign heading = heading_r;

  `PO_ASSERT_NXT(a_pose_holds, clk, rst_n, !cmd.commit,
                 $stable(x_accum_r) && $stable(y_accum_r) && $stable(heading_r))

endmodule

[sv/planar_odometry_integrator.sv]
// Planar dead-reckoning odometry integrator with midpoint heading.
// A request is taken only in the idle state: it is loaded, the rate and speed
// products are formed, their low and high halves pass the single shared scaling
// multiplier, then rounding, quadrant fold, one CORDIC rotation per cycle, and
// the pose commit once the output is free. The iterative CORDIC is the longest
// step. The pose registers serve as the result register, so a new request is
// taken while the previous pose still waits on out_tready.
// Depends on po_int_pkg, po_int_ctrl and po_int_dp.
module planar_odometry_integrator
  import po_int_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // yaw_rate[15:0], speed[31:16], time_step[48:32], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata   // pos_x[31:0], pos_y[63:32], heading[95:64]
);

  po_cmd_t                   cmd;
  logic signed [POS_W-1:0]   pos_x, pos_y;
  logic        [HEAD_W-1:0]  heading;

  po_int_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  po_int_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .yaw_rate  ($signed(in_tdata[15:0])),
    .speed     ($signed(in_tdata[31:16])),
    .time_step (in_tdata[48:32]),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .heading   (heading)
  );

  assign out_tdata = {heading, pos_y, pos_x};

endmodule
